// ===== rtl/pidd_pkg.sv =====
// Shared widths, default parameter values, register indexes and codes for the PID controller.
package pidd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 15;
  localparam int SUM_LIM_W  = 30;
  localparam int DRIVE_W    = 16;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int PROD_W     = 32;
  localparam int ISUM_W     = SUM_LIM_W + 1;
  localparam int ITERM_W    = GAIN_W + ISUM_W;
  localparam int TOT_W      = ITERM_W + 1;
  localparam int DIG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SUM_LIM_W;

  localparam int OUTPUT_LIMIT_DEF   = 32767;
  localparam int INTEGRAL_LIMIT_DEF = 1073741823;
  localparam int SCALE_DEF          = 128;
  localparam int DEADBAND_DEF       = 2;
  localparam int SAMPLE_BITS_DEF    = 16;

  localparam logic [GAIN_W-1:0]    ERR_LIMIT_RST = 15'h7FFF;
  localparam logic [SUM_LIM_W-1:0] SUM_LIMIT_RST = 30'h3FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN      = 3'd0,
    REG_I_GAIN      = 3'd1,
    REG_D_GAIN      = 3'd2,
    REG_ERROR_LIMIT = 3'd3,
    REG_SUM_LIMIT   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ISEL_NORM = 2'd0,
    ISEL_POS  = 2'd1,
    ISEL_NEG  = 2'd2
  } isel_t;

endpackage

// ===== rtl/pid_controller_deadband.sv =====
// PID controller with deadband, saturating P term and clamped integrator.
//
//  channel | ports                                          | accepted when
//  --------+------------------------------------------------+------------------------
//  input   | in_operation, in_set_point, in_process_value   | in_valid && in_ready
//  result  | out_drive                                      | out_valid && out_ready
//  config  | cfg_index, cfg_data                            | cfg_valid && cfg_ready
//
// One transaction per cycle while out_ready stays high; eight register stages from input to
// result: input register, error/state update, I multiply, term sum, magnitude, reciprocal
// partial products, quotient, clamp into the output register. out_valid rises when the
// transaction reaches the output register.
// Integrator and last measurement update as a transaction leaves the input register.
// Each stage holds while the stage after it is full and stalled; cfg_ready is always high.
// Reset clears all valid bits, the state, and the config registers to their reset values.
module pid_controller_deadband #(
  parameter int OUTPUT_LIMIT   = pidd_pkg::OUTPUT_LIMIT_DEF,
  parameter int INTEGRAL_LIMIT = pidd_pkg::INTEGRAL_LIMIT_DEF,
  parameter int SCALE          = pidd_pkg::SCALE_DEF,
  parameter int DEADBAND       = pidd_pkg::DEADBAND_DEF,
  parameter int SAMPLE_BITS    = pidd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_operation,
  input  logic        [pidd_pkg::SAMPLE_W-1:0]   in_set_point,
  input  logic        [pidd_pkg::SAMPLE_W-1:0]   in_process_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pidd_pkg::DRIVE_W-1:0]    out_drive,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [pidd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [pidd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pidd_pkg::*;

  localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((64'd1 << SW) - 64'd1);
  localparam logic signed [ERR_W-1:0]   DB_POS = ERR_W'(DEADBAND);
  localparam logic signed [ERR_W-1:0]   DB_NEG = ERR_W'(-DEADBAND);
  localparam logic signed [PROD_W-1:0]  P_SAT  = PROD_W'(OUTPUT_LIMIT);
  localparam logic signed [ITERM_W-1:0] I_SAT  = ITERM_W'(INTEGRAL_LIMIT);
  localparam logic [TOT_W-1:0]          OLIM   = TOT_W'(OUTPUT_LIMIT);

  localparam int LOG_S = $clog2(SCALE);
  localparam int RSH   = TOT_W + LOG_S;
  localparam int MW    = TOT_W + 1;
  localparam int XH_W  = TOT_W - DIG_W;
  localparam int MH_W  = MW - DIG_W;
  localparam int PRD_W = TOT_W + MW;
  localparam logic [127:0] RECIP_FULL =
    (((128'd1 << RSH) - 128'd1) / 128'(SCALE)) + 128'd1;
  localparam logic [MW-1:0]    RECIP    = RECIP_FULL[MW-1:0];
  localparam logic [DIG_W-1:0] RECIP_LO = RECIP[DIG_W-1:0];
  localparam logic [MH_W-1:0]  RECIP_HI = RECIP[MW-1:DIG_W];

  // configuration registers
  logic [GAIN_W-1:0]    p_gain_r, i_gain_r, d_gain_r, err_limit_r;
  logic [SUM_LIM_W-1:0] sum_limit_r;

  // controller state
  logic signed [ISUM_W-1:0] isum_r;
  logic [SAMPLE_W-1:0]      lm_r;

  // stage registers
  logic                       v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  op_t                        op0_r;
  logic [SAMPLE_W-1:0]        sp0_r, pv0_r;
  logic                       z1_r, z2_r, z3_r, z4_r, n4_r, z5_r, n5_r, z6_r, n6_r;
  logic signed [PROD_W-1:0]   p1_r, d1_r, p2_r, d2_r;
  isel_t                      isel1_r;
  logic signed [ISUM_W-1:0]   isum1_r;
  logic signed [ITERM_W-1:0]  i2_r;
  logic signed [TOT_W-1:0]    tot3_r;
  logic [TOT_W-1:0]           mag4_r;
  logic [2*DIG_W-1:0]         pp_ll_r;
  logic [DIG_W+MH_W-1:0]      pp_lh_r;
  logic [XH_W+DIG_W-1:0]      pp_hl_r;
  logic [XH_W+MH_W-1:0]       pp_hh_r;
  logic [TOT_W-1:0]           q6_r;

  logic                       out_valid_r;
  logic signed [DRIVE_W-1:0]  out_drive_r;

  // load enables
  logic ld_out, ld1, ld2, ld3, ld4, ld5, ld6;

  // stage A signals
  logic signed [ERR_W-1:0]    err_a, diff_a, elim_a;
  logic                       is_clear, in_db, zero_a;
  logic signed [PROD_W-1:0]   p_mul, d_mul, p_nxt;
  logic signed [ISUM_W:0]     temp_a, slim_a, nslim_a;
  isel_t                      isel_nxt;
  logic signed [ISUM_W-1:0]   isum_nxt;

  // later stage signals
  logic signed [ITERM_W-1:0]  i_mul, i_nxt;
  logic signed [TOT_W-1:0]    tot_nxt;
  logic [TOT_W-1:0]           mag_nxt, q_nxt, q_clamp;
  logic [PRD_W-1:0]           prod_w;
  logic signed [DRIVE_W-1:0]  drive_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r    <= '0;
      i_gain_r    <= '0;
      d_gain_r    <= '0;
      err_limit_r <= ERR_LIMIT_RST;
      sum_limit_r <= SUM_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_P_GAIN:      p_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_I_GAIN:      i_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_D_GAIN:      d_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_ERROR_LIMIT: err_limit_r <= cfg_data[GAIN_W-1:0];
        REG_SUM_LIMIT:   sum_limit_r <= cfg_data[SUM_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake chain: a stage loads when empty or when its contents move on
  assign ld_out   = !out_valid_r || out_ready;
  assign ld6      = !v6_r || ld_out;
  assign ld5      = !v5_r || ld6;
  assign ld4      = !v4_r || ld5;
  assign ld3      = !v3_r || ld4;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_ready = !v0_r || ld1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ready) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op0_r <= op_t'(in_operation);
      sp0_r <= in_set_point & SMASK;
      pv0_r <= in_process_value & SMASK;
    end
  end

  // stage A: error, deadband, P and D products, integrator update
  always_comb begin
    err_a    = $signed({1'b0, sp0_r}) - $signed({1'b0, pv0_r});
    diff_a   = $signed({1'b0, lm_r}) - $signed({1'b0, pv0_r});
    elim_a   = $signed({2'b00, err_limit_r});
    is_clear = (op0_r == OP_CLEAR);
    in_db    = (err_a <= DB_POS) && (err_a >= DB_NEG);
    zero_a   = is_clear || in_db;

    p_mul = $signed({{(PROD_W-GAIN_W){1'b0}}, p_gain_r}) * PROD_W'(err_a);
    d_mul = $signed({{(PROD_W-GAIN_W){1'b0}}, d_gain_r}) * PROD_W'(diff_a);

    if (err_a > elim_a) begin
      p_nxt = P_SAT;
    end else if (err_a < -elim_a) begin
      p_nxt = -P_SAT;
    end else begin
      p_nxt = p_mul;
    end

    temp_a  = $signed({isum_r[ISUM_W-1], isum_r}) + (ISUM_W+1)'(err_a);
    slim_a  = $signed({2'b00, sum_limit_r});
    nslim_a = -slim_a;
    if (temp_a > slim_a) begin
      isel_nxt = ISEL_POS;
      isum_nxt = slim_a[ISUM_W-1:0];
    end else if (temp_a < nslim_a) begin
      isel_nxt = ISEL_NEG;
      isum_nxt = nslim_a[ISUM_W-1:0];
    end else begin
      isel_nxt = ISEL_NORM;
      isum_nxt = temp_a[ISUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isum_r <= '0;
      lm_r   <= '0;
    end else if (v0_r && ld1) begin
      if (is_clear) begin
        isum_r <= '0;
      end else if (!in_db) begin
        isum_r <= isum_nxt;
        lm_r   <= pv0_r;
      end
    end
  end

  // stage registers 1..6
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= v0_r;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
      if (ld6) v6_r <= v5_r;
    end
  end

  always_comb begin
    i_mul = $signed({{(ITERM_W-GAIN_W){1'b0}}, i_gain_r}) * ITERM_W'(isum1_r);
    case (isel1_r)
      ISEL_POS: i_nxt = I_SAT;
      ISEL_NEG: i_nxt = -I_SAT;
      default:  i_nxt = i_mul;
    endcase
    tot_nxt = TOT_W'(p2_r) + TOT_W'(d2_r) + TOT_W'(i2_r);
    mag_nxt = tot3_r[TOT_W-1] ? TOT_W'(-tot3_r) : TOT_W'(tot3_r);
    // divide the magnitude by SCALE: rounded-up reciprocal, keep the high bits
    prod_w  = PRD_W'(pp_ll_r) + (PRD_W'(pp_lh_r) << DIG_W) + (PRD_W'(pp_hl_r) << DIG_W) +
              (PRD_W'(pp_hh_r) << (2*DIG_W));
    q_nxt   = TOT_W'(prod_w >> RSH);
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      z1_r    <= zero_a;
      p1_r    <= p_nxt;
      d1_r    <= d_mul;
      isel1_r <= isel_nxt;
      isum1_r <= isum_nxt;
    end
    if (ld2) begin
      z2_r <= z1_r;
      p2_r <= p1_r;
      d2_r <= d1_r;
      i2_r <= i_nxt;
    end
    if (ld3) begin
      z3_r   <= z2_r;
      tot3_r <= tot_nxt;
    end
    if (ld4) begin
      z4_r   <= z3_r;
      n4_r   <= tot3_r[TOT_W-1];
      mag4_r <= mag_nxt;
    end
    if (ld5) begin
      z5_r    <= z4_r;
      n5_r    <= n4_r;
      pp_ll_r <= (2*DIG_W)'(mag4_r[DIG_W-1:0]) * (2*DIG_W)'(RECIP_LO);
      pp_lh_r <= (DIG_W+MH_W)'(mag4_r[DIG_W-1:0]) * (DIG_W+MH_W)'(RECIP_HI);
      pp_hl_r <= (XH_W+DIG_W)'(mag4_r[TOT_W-1:DIG_W]) * (XH_W+DIG_W)'(RECIP_LO);
      pp_hh_r <= (XH_W+MH_W)'(mag4_r[TOT_W-1:DIG_W]) * (XH_W+MH_W)'(RECIP_HI);
    end
    if (ld6) begin
      z6_r <= z5_r;
      n6_r <= n5_r;
      q6_r <= q_nxt;
    end
  end

  // clamp, restore sign, drop to drive width; zero for clear or deadband
  always_comb begin
    q_clamp = (q6_r > OLIM) ? OLIM : q6_r;
    if (z6_r) begin
      drive_nxt = '0;
    end else if (n6_r) begin
      drive_nxt = -$signed(q_clamp[DRIVE_W-1:0]);
    end else begin
      drive_nxt = $signed(q_clamp[DRIVE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_drive_r <= drive_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  a_clear_zeroes_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && ld1 && op0_r == OP_CLEAR) |=> (isum_r == '0))
    else $error("integrator not cleared");

  a_deadband_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && ld1 && op0_r == OP_SAMPLE && in_db) |=> ($stable(isum_r) && $stable(lm_r)))
    else $error("state changed inside deadband");

  a_sum_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && ld1 && op0_r == OP_SAMPLE && !in_db) |=>
      (isum_r <= $signed({1'b0, $past(sum_limit_r)}) &&
       isum_r >= -$signed({1'b0, $past(sum_limit_r)})))
    else $error("integrator outside its limit");

  a_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_out && v6_r && z6_r) |=> (out_valid && out_drive == '0))
    else $error("nonzero drive for clear or deadband");

endmodule
